### hw/rtl/uart_pkg.sv
// Shared types, constants and the bit-period counter step for the 8N1 UART
// with receive FIFO. No dependencies; used by every module in hw/rtl.
package uart_pkg;

   localparam int FifoDepth = 16;
   localparam int FifoAw    = $clog2(FifoDepth);
   localparam int FifoCw    = $clog2(FifoDepth + 1);
   localparam int BitTimeW  = 16;
   localparam int DataW     = 8;

   localparam logic [BitTimeW-1:0] BitTimeReset = BitTimeW'(18);
   localparam logic [BitTimeW-1:0] TickSat      = '1;
   localparam logic [3:0]          TxLastData   = 4'd8;
   localparam logic [3:0]          TxStopBit    = 4'd9;
   localparam logic [2:0]          RxLastBit    = 3'd7;

   typedef struct packed {
      logic             done;
      logic [BitTimeW-1:0] count;
   } period_type;

   typedef struct packed {
      logic             have_byte;
      logic [DataW-1:0] data;
   } rx_byte_type;

   typedef struct packed {
      logic level;
      logic busy;
   } tx_status_type;

   // One tick of a bit period: saturating count, period ends at or past bit_time.
   function automatic period_type period_step(input logic [BitTimeW-1:0] count,
                                              input logic [BitTimeW-1:0] bit_time);
      period_type       res;
      logic [BitTimeW-1:0] nxt;
      nxt = (count == TickSat) ? count : count + BitTimeW'(1);
      res.done  = (nxt >= bit_time);
      res.count = res.done ? '0 : nxt;
      return res;
   endfunction

   function automatic logic [FifoAw-1:0] next_slot(input logic [FifoAw-1:0] p);
      return (p == FifoAw'(FifoDepth - 1)) ? '0 : p + FifoAw'(1);
   endfunction

endpackage

### hw/rtl/uart_rx.sv
// UART receiver: start-edge detect and eight timed data samples, LSB first.
// Depends on uart_pkg.
module uart_rx (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_en,
   input  logic                          rx_level,
   input  logic [uart_pkg::BitTimeW-1:0] bit_time,
   output uart_pkg::rx_byte_type         rx_byte
);
   import uart_pkg::*;

   logic                prev_ff, prev_in;
   logic                active_ff, active_in;
   logic [BitTimeW-1:0] count_ff, count_in;
   logic [2:0]          idx_ff, idx_in;
   logic [DataW-1:0]    shift_ff, shift_in;
   period_type          per;

   always_comb begin
      per       = period_step(count_ff, bit_time);
      prev_in   = rx_level;
      active_in = active_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      shift_in  = shift_ff;
      rx_byte.have_byte = 1'b0;
      rx_byte.data      = '0;
      if (active_ff) begin
         count_in = per.count;
         if (per.done) begin
            shift_in = {rx_level, shift_ff[DataW-1:1]};
            idx_in   = idx_ff + 3'd1;
            if (idx_ff == RxLastBit) begin
               rx_byte.have_byte = tick_en;
               rx_byte.data      = shift_in;
               active_in         = 1'b0;
               idx_in            = '0;
            end
         end
      end else if (prev_ff && !rx_level) begin
         active_in = 1'b1;
         count_in  = '0;
         idx_in    = '0;
         shift_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 1'b1;
         active_ff <= 1'b0;
         count_ff  <= '0;
         idx_ff    <= '0;
         shift_ff  <= '0;
      end else if (tick_en) begin
         prev_ff   <= prev_in;
         active_ff <= active_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         shift_ff  <= shift_in;
      end
   end

endmodule

### hw/rtl/uart_tx.sv
// UART transmitter: start bit, eight data bits LSB first, one stop bit.
// Depends on uart_pkg.
module uart_tx (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_en,
   input  logic                          tx_start,
   input  logic [uart_pkg::DataW-1:0]    tx_byte,
   input  logic [uart_pkg::BitTimeW-1:0] bit_time,
   output uart_pkg::tx_status_type       tx_status
);
   import uart_pkg::*;

   logic                active_ff, active_in;
   logic                line_ff, line_in;
   logic [BitTimeW-1:0] count_ff, count_in;
   logic [3:0]          idx_ff, idx_in;
   logic [DataW-1:0]    shift_ff, shift_in;
   period_type          per;

   always_comb begin
      per       = period_step(count_ff, bit_time);
      active_in = active_ff;
      line_in   = line_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      shift_in  = shift_ff;
      if (active_ff) begin
         count_in = per.count;
         if (per.done) begin
            idx_in = idx_ff + 4'd1;
            if (idx_in <= TxLastData) begin
               line_in = shift_ff[idx_ff[2:0]];
            end else if (idx_in == TxStopBit) begin
               line_in = 1'b1;
            end else begin
               // stop bit done: back to idle
               line_in   = 1'b1;
               active_in = 1'b0;
               idx_in    = '0;
            end
         end
      end else if (tx_start) begin
         active_in = 1'b1;
         count_in  = '0;
         idx_in    = '0;
         shift_in  = tx_byte;
         line_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         line_ff   <= 1'b1;
         count_ff  <= '0;
         idx_ff    <= '0;
         shift_ff  <= '0;
      end else if (tick_en) begin
         active_ff <= active_in;
         line_ff   <= line_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         shift_ff  <= shift_in;
      end
   end

   assign tx_status.level = line_ff;
   assign tx_status.busy  = active_ff;

endmodule

### hw/rtl/uart_rxfifo.sv
// Receive FIFO: byte memory with registered read, head/tail pointers and count.
// Pop is served before push; a push into a full FIFO is dropped. Depends on uart_pkg.
module uart_rxfifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick_en,
   input  logic                        pop_req,
   input  uart_pkg::rx_byte_type       rx_byte,
   output logic                        pop_valid,
   output logic [uart_pkg::DataW-1:0]  pop_byte,
   output logic [uart_pkg::FifoCw-1:0] fifo_level,
   output logic                        byte_dropped
);
   import uart_pkg::*;

   logic [DataW-1:0]  mem [FifoDepth];
   logic [DataW-1:0]  rd_data_ff;
   logic [FifoAw-1:0] head_ff, head_in;
   logic [FifoAw-1:0] tail_ff, tail_in;
   logic [FifoCw-1:0] count_ff, count_in, count_popped;
   logic              pop_valid_ff, dropped_ff;
   logic              do_pop, do_push, drop;

   always_comb begin
      do_pop       = tick_en && pop_req && (count_ff != '0);
      count_popped = do_pop ? count_ff - FifoCw'(1) : count_ff;
      drop         = rx_byte.have_byte && (count_popped == FifoCw'(FifoDepth));
      do_push      = rx_byte.have_byte && !drop;
      count_in     = do_push ? count_popped + FifoCw'(1) : count_popped;
      head_in      = do_pop  ? next_slot(head_ff) : head_ff;
      tail_in      = do_push ? next_slot(tail_ff) : tail_ff;
   end

   // Read-first: a push into the slot being popped this cycle returns old data.
   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_data_ff <= mem[head_ff];
      end
      if (do_push) begin
         mem[tail_ff] <= rx_byte.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
         dropped_ff   <= 1'b0;
      end else if (tick_en) begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pop_valid_ff <= do_pop;
         dropped_ff   <= drop;
      end
   end

   assign pop_valid    = pop_valid_ff;
   assign pop_byte     = pop_valid_ff ? rd_data_ff : '0;
   assign fifo_level   = count_ff;
   assign byte_dropped = dropped_ff;

endmodule

### hw/rtl/uart_8n1_with_receive_fifo_top.sv
// Top level of the 8N1 UART with receive FIFO.
// Depends on uart_pkg, uart_rx, uart_tx and uart_rxfifo.
//
// Usage:
//  - req_* carries one serial tick per transaction: receive line level, a
//    transmit request with its byte, and a pop request for the receive FIFO.
//  - rsp_* returns one transaction per request: transmit line and busy after
//    the tick, the popped byte (0 if none), the FIFO fill level and a drop flag.
//  - csr_* writes bit_time (ticks per serial bit, reset 18); csr_ready is
//    always high. Write it only while no request is outstanding.
//  - The response is registered at the edge that takes its request. Throughput
//    is one request per cycle while req_stall is low; all state updates (rx and
//    tx counters, FIFO pointers, FIFO memory read and write) complete in the
//    cycle of acceptance, and the memory read data register holds the popped byte.
//  - Reset clears all control state; the line levels return to idle high and
//    the FIFO is empty. No clearing pass is needed: FIFO entries are read
//    only after they are written.
//  - While rsp_stall holds a pending response, req_stall is raised and the
//    state freezes; a request is taken in the same cycle the response leaves.
module uart_8n1_with_receive_fifo_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_rx_level,
   input  logic                          req_tx_start,
   input  logic [uart_pkg::DataW-1:0]    req_tx_byte,
   input  logic                          req_pop_req,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_tx_level,
   output logic                          rsp_tx_busy,
   output logic                          rsp_pop_valid,
   output logic [uart_pkg::DataW-1:0]    rsp_pop_byte,
   output logic [uart_pkg::FifoCw-1:0]   rsp_fifo_level,
   output logic                          rsp_byte_dropped,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [uart_pkg::BitTimeW-1:0] csr_data
);
   import uart_pkg::*;

   logic                csr_write;
   logic [BitTimeW-1:0] bit_time_ff, bit_time_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                tick_en;
   rx_byte_type         rx_byte;
   tx_status_type       tx_status;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign tick_en   = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = tick_en || (rsp_valid_ff && rsp_stall);
      csr_write    = csr_valid && csr_ready;
      bit_time_in  = csr_write ? csr_data : bit_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_time_ff  <= BitTimeReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         bit_time_ff  <= bit_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   uart_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .tick_en  (tick_en),
      .rx_level (req_rx_level),
      .bit_time (bit_time_ff),
      .rx_byte  (rx_byte)
   );

   uart_tx u_tx (
      .clock     (clock),
      .reset     (reset),
      .tick_en   (tick_en),
      .tx_start  (req_tx_start),
      .tx_byte   (req_tx_byte),
      .bit_time  (bit_time_ff),
      .tx_status (tx_status)
   );

   uart_rxfifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (tick_en),
      .pop_req      (req_pop_req),
      .rx_byte      (rx_byte),
      .pop_valid    (rsp_pop_valid),
      .pop_byte     (rsp_pop_byte),
      .fifo_level   (rsp_fifo_level),
      .byte_dropped (rsp_byte_dropped)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tx_level = tx_status.level;
   assign rsp_tx_busy  = tx_status.busy;

   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_fifo_level <= FifoCw'(FifoDepth))
      else $error("fifo level above depth");

   a_drop_when_full : assert property (@(posedge clock) disable iff (reset)
      rsp_byte_dropped |-> (rsp_fifo_level == FifoCw'(FifoDepth)))
      else $error("byte dropped while fifo not full");

   a_idle_line_high : assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tx_busy) |-> rsp_tx_level)
      else $error("transmit line not idle high after frame");

   a_frozen_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_fifo_level) && $stable(rsp_pop_byte)))
      else $error("state advanced while response stalled");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for uart_8n1_with_receive_fifo_top: serial ticks in,
// one line/FIFO status transaction out, checked against a cycle-level predictor.
// Depends on uart_pkg and the top level in hw/rtl.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import uart_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int HoldoffCycles = 240;
   localparam int MaxReports    = 100;

   typedef struct packed {
      logic             rx_level;
      logic             tx_start;
      logic [DataW-1:0] tx_byte;
      logic             pop_req;
   } tick_item_type;

   typedef struct packed {
      logic              tx_level;
      logic              tx_busy;
      logic              pop_valid;
      logic [DataW-1:0]  pop_byte;
      logic [FifoCw-1:0] fifo_level;
      logic              byte_dropped;
   } tick_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_rx_level;
   logic                req_tx_start;
   logic [DataW-1:0]    req_tx_byte;
   logic                req_pop_req;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_tx_level;
   logic                rsp_tx_busy;
   logic                rsp_pop_valid;
   logic [DataW-1:0]    rsp_pop_byte;
   logic [FifoCw-1:0]   rsp_fifo_level;
   logic                rsp_byte_dropped;
   logic                csr_valid;
   logic                csr_ready;
   logic [BitTimeW-1:0] csr_data;

   always #2 clock = ~clock;

   uart_8n1_with_receive_fifo_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_level     (req_rx_level),
      .req_tx_start     (req_tx_start),
      .req_tx_byte      (req_tx_byte),
      .req_pop_req      (req_pop_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_level     (rsp_tx_level),
      .rsp_tx_busy      (rsp_tx_busy),
      .rsp_pop_valid    (rsp_pop_valid),
      .rsp_pop_byte     (rsp_pop_byte),
      .rsp_fifo_level   (rsp_fifo_level),
      .rsp_byte_dropped (rsp_byte_dropped),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   // ---------------------------------------------------------------- predictor
   logic [BitTimeW-1:0] bit_time_q;
   logic                rx_prev_q;
   logic                rx_busy_q;
   logic [BitTimeW-1:0] rx_ticks_q;
   logic [3:0]          rx_bits_q;
   logic [DataW-1:0]    rx_sr_q;
   logic                tx_busy_q;
   logic [BitTimeW-1:0] tx_ticks_q;
   logic [3:0]          tx_bits_q;
   logic [DataW-1:0]    tx_sr_q;
   logic                tx_line_q;
   logic [DataW-1:0]    fifo_mem_q [FifoDepth];
   logic [FifoAw-1:0]   rd_ptr_q;
   logic [FifoAw-1:0]   wr_ptr_q;
   logic [FifoCw-1:0]   fifo_fill_q;

   tick_result_type pending_tick_results[$];
   logic            rx_line_q[$];

   int  mismatches   = 0;
   int  burst_left   = 0;
   int  stall_run    = 0;
   int  idle_cycles  = 0;
   logic stall_level = 1'b0;
   logic gaps_on     = 1'b1;
   logic stall_on    = 1'b1;
   logic holdoff_req = 1'b0;

   task automatic reset_uart_model();
      bit_time_q  = BitTimeReset;
      rx_prev_q   = 1'b1;
      rx_busy_q   = 1'b0;
      rx_ticks_q  = '0;
      rx_bits_q   = '0;
      rx_sr_q     = '0;
      tx_busy_q   = 1'b0;
      tx_ticks_q  = '0;
      tx_bits_q   = '0;
      tx_sr_q     = '0;
      tx_line_q   = 1'b1;
      rd_ptr_q    = '0;
      wr_ptr_q    = '0;
      fifo_fill_q = '0;
   endtask

   // Count one tick of a bit period; MSB set when the period ends.
   function automatic logic [BitTimeW:0] count_tick(input logic [BitTimeW-1:0] cnt);
      logic [BitTimeW-1:0] nxt;
      nxt = (cnt == '1) ? cnt : cnt + BitTimeW'(1);
      if (nxt >= bit_time_q)
         return {1'b1, BitTimeW'(0)};
      return {1'b0, nxt};
   endfunction

   function automatic tick_result_type advance_uart(input tick_item_type it);
      tick_result_type     res;
      logic [BitTimeW:0]   cs;
      logic                got_byte;
      logic [DataW-1:0]    rx_data;
      res      = '0;
      got_byte = 1'b0;
      rx_data  = '0;

      if (rx_busy_q) begin
         cs = count_tick(rx_ticks_q);
         rx_ticks_q = cs[BitTimeW-1:0];
         if (cs[BitTimeW]) begin
            rx_sr_q   = {it.rx_level, rx_sr_q[DataW-1:1]};
            rx_bits_q = rx_bits_q + 4'd1;
            if (rx_bits_q >= 4'(DataW)) begin
               got_byte  = 1'b1;
               rx_data   = rx_sr_q;
               rx_busy_q = 1'b0;
               rx_bits_q = '0;
            end
         end
      end else if (rx_prev_q && !it.rx_level) begin
         rx_busy_q  = 1'b1;
         rx_ticks_q = '0;
         rx_bits_q  = '0;
         rx_sr_q    = '0;
      end
      rx_prev_q = it.rx_level;

      if (tx_busy_q) begin
         cs = count_tick(tx_ticks_q);
         tx_ticks_q = cs[BitTimeW-1:0];
         if (cs[BitTimeW]) begin
            tx_bits_q = tx_bits_q + 4'd1;
            if (tx_bits_q <= TxLastData) begin
               tx_line_q = tx_sr_q[3'(tx_bits_q - 4'd1)];
            end else if (tx_bits_q == TxStopBit) begin
               tx_line_q = 1'b1;
            end else begin
               tx_line_q = 1'b1;
               tx_busy_q = 1'b0;
               tx_bits_q = '0;
            end
         end
      end else if (it.tx_start) begin
         tx_busy_q  = 1'b1;
         tx_ticks_q = '0;
         tx_bits_q  = '0;
         tx_sr_q    = it.tx_byte;
         tx_line_q  = 1'b0;
      end

      // serve the pop before the push so a full FIFO can take a byte this tick
      if (it.pop_req && fifo_fill_q != '0) begin
         res.pop_valid = 1'b1;
         res.pop_byte  = fifo_mem_q[rd_ptr_q];
         rd_ptr_q      = rd_ptr_q + FifoAw'(1);
         fifo_fill_q   = fifo_fill_q - FifoCw'(1);
      end
      if (got_byte) begin
         if (fifo_fill_q >= FifoCw'(FifoDepth)) begin
            res.byte_dropped = 1'b1;
         end else begin
            fifo_mem_q[wr_ptr_q] = rx_data;
            wr_ptr_q    = wr_ptr_q + FifoAw'(1);
            fifo_fill_q = fifo_fill_q + FifoCw'(1);
         end
      end

      res.tx_level   = tx_line_q;
      res.tx_busy    = tx_busy_q;
      res.fifo_level = fifo_fill_q;
      return res;
   endfunction

   // ------------------------------------------------------- receive line source
   function automatic void queue_rx_frame(input logic [DataW-1:0] data, input int data_bits);
      int unsigned b;
      b = (bit_time_q == 0) ? 1 : int'(bit_time_q);
      rx_line_q.push_back(1'b1);
      repeat (b) rx_line_q.push_back(1'b0);
      for (int i = 0; i < data_bits; i++)
         repeat (b) rx_line_q.push_back(data[i]);
      repeat (b * $urandom_range(1, 3)) rx_line_q.push_back(1'b1);
   endfunction

   function automatic logic next_rx_level();
      int unsigned pick;
      if (rx_line_q.size() == 0) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            repeat ($urandom_range(1, 6)) rx_line_q.push_back(1'($urandom));
         else if (pick == 1)
            queue_rx_frame(8'($urandom), $urandom_range(0, 7));  // cut-off frame
         else
            queue_rx_frame(8'($urandom), DataW);
      end
      return rx_line_q.pop_front();
   endfunction

   function automatic tick_item_type random_tick(input int pop_pct);
      tick_item_type it;
      it.rx_level = next_rx_level();
      it.tx_start = tx_busy_q ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 3) == 0);
      it.tx_byte  = 8'($urandom);
      it.pop_req  = ($urandom_range(0, 99) < pop_pct);
      return it;
   endfunction

   // ------------------------------------------------------------------ drivers
   // Called at a falling edge; returns at a falling edge, with valid low if a gap was taken.
   task automatic send_tick(input tick_item_type it);
      req_valid    <= 1'b1;
      req_rx_level <= it.rx_level;
      req_tx_start <= it.tx_start;
      req_tx_byte  <= it.tx_byte;
      req_pop_req  <= it.pop_req;
      do @(posedge clock); while (req_stall);
      pending_tick_results.push_back(advance_uart(it));
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (gaps_on) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Hold the sender until every outstanding transaction has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_tick_results.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_bit_time(input logic [BitTimeW-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      bit_time_q = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(input int count, input int pop_pct);
      repeat (count) send_tick(random_tick(pop_pct));
   endtask

   // ------------------------------------------------------------------- tests
   task automatic test_directed();
      tick_item_type it;
      // reset bit time: pop on empty, start 0xFF, start while busy ignored
      it = '{rx_level: 1'b1, tx_start: 1'b1, tx_byte: 8'hFF, pop_req: 1'b1};
      send_tick(it);
      it = '{rx_level: 1'b0, tx_start: 1'b1, tx_byte: 8'h00, pop_req: 1'b1};
      send_tick(it);
      it = '{rx_level: 1'b1, tx_start: 1'b0, tx_byte: 8'h5A, pop_req: 1'b0};
      send_tick(it);
      drain();
      // fastest rate: receive 0xFF then 0x00, keep start high for back-to-back frames
      write_bit_time(BitTimeW'(1));
      rx_line_q.delete();
      queue_rx_frame(8'hFF, DataW);
      queue_rx_frame(8'h00, DataW);
      for (int i = 0; i < 22; i++) begin
         it.rx_level = rx_line_q.pop_front();
         it.tx_start = 1'b1;
         it.tx_byte  = (i < 11) ? 8'h00 : 8'hFF;
         it.pop_req  = (i >= 19);
         send_tick(it);
      end
      drain();
   endtask

   task automatic test_retime_midframe();
      write_bit_time(BitTimeW'(6));
      rx_line_q.delete();
      send_random(20, 0);
      drain();
      // lower while counts may already be past the new period
      write_bit_time(BitTimeW'(2));
      send_random(30, 20);
      drain();
      write_bit_time(BitTimeW'(9));
      send_random(40, 20);
      drain();
   endtask

   task automatic test_bit_time_extremes();
      tick_item_type it;
      write_bit_time(BitTimeW'(0));
      rx_line_q.delete();
      send_random(24, 30);
      drain();
      write_bit_time(BitTimeW'(16'hFFFF));
      for (int i = 0; i < 30; i++) begin
         it.rx_level = (i < 2) || (i > 20);
         it.tx_start = (i == 3);
         it.tx_byte  = 8'($urandom);
         it.pop_req  = (i == 5);
         send_tick(it);
      end
      drain();
      // both frames are mid-bit with large counts; each tick now ends a bit
      write_bit_time(BitTimeW'(1));
      rx_line_q.delete();
      send_random(25, 20);
      drain();
   endtask

   task automatic test_backpressure();
      write_bit_time(BitTimeW'(1));
      rx_line_q.delete();
      gaps_on     = 1'b0;
      stall_on    = 1'b0;
      holdoff_req = 1'b1;
      send_random(80, 0);
      drain();
      send_random(60, 50);
      drain();
      gaps_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   task automatic test_random_traffic(input logic [BitTimeW-1:0] bt, input int count,
                                      input int pop_pct);
      write_bit_time(bt);
      rx_line_q.delete();
      send_random(count, pop_pct);
      drain();
   endtask

   // ------------------------------------------------------------ result check
   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MaxReports)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   tick_result_type want_q;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tick_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("%0t ns: transaction with none outstanding, expected none, actual %0h",
                        $time, rsp_pop_byte);
         end else begin
            want_q = pending_tick_results.pop_front();
            check_field("tx_level", 8'(want_q.tx_level), 8'(rsp_tx_level));
            check_field("tx_busy", 8'(want_q.tx_busy), 8'(rsp_tx_busy));
            check_field("pop_valid", 8'(want_q.pop_valid), 8'(rsp_pop_valid));
            check_field("pop_byte", want_q.pop_byte, rsp_pop_byte);
            check_field("fifo_level", 8'(want_q.fifo_level), 8'(rsp_fifo_level));
            check_field("byte_dropped", 8'(want_q.byte_dropped), 8'(rsp_byte_dropped));
         end
      end
   end

   // Receiver: long hold-off on request, otherwise alternating stall runs while stall_on is set.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            rsp_stall <= 1'b1;
            repeat (HoldoffCycles) @(negedge clock);
            holdoff_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (stall_on) begin
            if (stall_run == 0) begin
               stall_level = !stall_level;
               stall_run   = stall_level ? $urandom_range(1, 4) : $urandom_range(1, 12);
            end
            stall_run--;
            rsp_stall <= stall_level;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_level = 1'b1;
      req_tx_start = 1'b0;
      req_tx_byte  = '0;
      req_pop_req  = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      reset_uart_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_retime_midframe();
      test_bit_time_extremes();
      test_backpressure();
      // few pops: fill the FIFO and force drops
      test_random_traffic(BitTimeW'(1), 300, 2);
      // no idling on either side while the FIFO empties
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      test_random_traffic(BitTimeW'(1), 150, 70);
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      test_random_traffic(BitTimeW'(2), 200, 30);
      test_random_traffic(BitTimeW'(3), 150, 15);
      repeat (4)
         test_random_traffic(BitTimeW'($urandom_range(1, 5)), 50, $urandom_range(0, 80));

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
